@@ rtl/core/tpmq_pkg.sv @@
// ----------------------------------------------------------------------------
// tpmq_pkg
// Shared types and constants for the tree path maximum edge query core:
// opcodes, status codes, memory sizes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tpmq_pkg;

    // sizes of the stores
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = MAX_VERTICES - 1;
    localparam int STACK_DEPTH  = 2 * MAX_VERTICES;
    localparam int COST_BITS    = 32;
    localparam int VTX_BITS     = 10;
    localparam int CNT_BITS     = 11;
    localparam int SP_BITS      = 12;

    localparam logic [COST_BITS-1:0] COST_MIN = {1'b1, {(COST_BITS-1){1'b0}}};

    // item opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CHG   = 2'd2;
    localparam logic [1:0] OP_CLR   = 2'd3;

    // query status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SAME   = 2'd1;
    localparam logic [1:0] ST_UNREACH = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        DP_NOP       = 5'd0,
        DP_LATCH     = 5'd1,
        DP_EXEC      = 5'd2,
        DP_RES_BAD   = 5'd3,
        DP_RES_SAME  = 5'd4,
        DP_CLR_START = 5'd5,
        DP_CLR_STEP  = 5'd6,
        DP_PUSH_SRC  = 5'd7,
        DP_POP       = 5'd8,
        DP_VIS_RD_V  = 5'd9,
        DP_MARK      = 5'd10,
        DP_EP_RD     = 5'd11,
        DP_VIS_RD_W  = 5'd12,
        DP_LINK      = 5'd13,
        DP_NEXT_E    = 5'd14,
        DP_RES_OK    = 5'd15,
        DP_PAR_RD    = 5'd16,
        DP_PAR_LATCH = 5'd17,
        DP_WALK_CMP  = 5'd18,
        DP_OUT       = 5'd19
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] item_op;
        logic       q_bad;
        logic       q_same;
        logic       clr_last;
        logic       stack_empty;
        logic       visited;
        logic       is_tgt;
        logic       no_edges;
        logic       edge_hit;
        logic       last_edge;
        logic       at_src;
        logic       out_free;
    } sts_t;

endpackage

@@ rtl/core/tpmq_datapath.sv @@
// ----------------------------------------------------------------------------
// tpmq_datapath
// Edge store, visit marks, parent table, search stack and the registers of
// one query; performs the single operation the controller issues each cycle.
// ----------------------------------------------------------------------------
module tpmq_datapath
    import tpmq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  cfg_valid,
    input  logic [CNT_BITS-1:0]   cfg_data,
    input  logic [1:0]            opcode,
    input  logic [VTX_BITS-1:0]   node_a,
    input  logic [VTX_BITS-1:0]   node_b,
    input  logic [VTX_BITS-1:0]   edge_sel,
    input  logic [COST_BITS-1:0]  edge_cost,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [COST_BITS-1:0]  path_max_cost,
    output logic [1:0]            query_status
);

    localparam logic [CNT_BITS-1:0] VTX_LIMIT = CNT_BITS'(MAX_VERTICES);
    localparam logic [VTX_BITS-1:0] EDGE_LIMIT = VTX_BITS'(MAX_EDGES);

    // memories
    logic [2*VTX_BITS-1:0] ep_mem    [0:MAX_EDGES-1];
    logic [COST_BITS-1:0]  cost_mem  [0:MAX_EDGES-1];
    logic                  vis_mem   [0:MAX_VERTICES-1];
    logic [VTX_BITS-1:0]   par_mem   [0:MAX_VERTICES-1];
    logic [VTX_BITS-1:0]   stk_mem   [0:STACK_DEPTH-1];

    logic [2*VTX_BITS-1:0] ep_q;
    logic [COST_BITS-1:0]  cost_q;
    logic                  vis_q;
    logic [VTX_BITS-1:0]   par_q;
    logic [VTX_BITS-1:0]   stk_q;

    // control registers
    logic [CNT_BITS-1:0]  vc_reg, vc_next;
    logic [VTX_BITS-1:0]  cnt_reg, cnt_next;
    logic [SP_BITS-1:0]   sp_reg, sp_next;
    logic [VTX_BITS-1:0]  e_reg, e_next;
    logic [CNT_BITS-1:0]  clr_reg, clr_next;
    logic                 out_valid_reg, out_valid_next;

    // payload registers
    logic [1:0]           op_reg;
    logic [VTX_BITS-1:0]  a_reg, b_reg, idx_reg;
    logic [COST_BITS-1:0] cost_reg;
    logic [VTX_BITS-1:0]  v_reg, v_next;
    logic [VTX_BITS-1:0]  w_reg, w_next;
    logic [VTX_BITS-1:0]  node_reg, node_next;
    logic [VTX_BITS-1:0]  p_reg, p_next;
    logic [COST_BITS-1:0] best_reg, best_next;
    logic [COST_BITS-1:0] res_cost_reg, res_cost_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic [COST_BITS-1:0] out_cost_reg, out_cost_next;
    logic [1:0]           out_status_reg, out_status_next;

    // memory port controls
    logic                  ep_we, cost_we, vis_we, par_we, stk_we;
    logic                  ep_re, vis_re, par_re, stk_re;
    logic [VTX_BITS-1:0]   ep_wa, cost_wa, vis_wa, par_wa, vis_ra;
    logic [VTX_BITS:0]     stk_wa, stk_ra;
    logic [2*VTX_BITS-1:0] ep_wd;
    logic [COST_BITS-1:0]  cost_wd;
    logic                  vis_wd;
    logic [VTX_BITS-1:0]   par_wd, stk_wd;

    // live vertex count
    logic [CNT_BITS-1:0] n;
    always_comb
    begin
        if (vc_reg == '0)
            n = CNT_BITS'(1);
        else if (vc_reg > VTX_LIMIT)
            n = VTX_LIMIT;
        else
            n = vc_reg;
    end

    // edge decode
    logic [VTX_BITS-1:0] ep_a, ep_b, w_comb;
    logic                ends_ok, edge_hit, walk_hit, last_edge;
    assign ep_a      = ep_q[2*VTX_BITS-1:VTX_BITS];
    assign ep_b      = ep_q[VTX_BITS-1:0];
    assign ends_ok   = ({1'b0, ep_a} < n) && ({1'b0, ep_b} < n);
    assign edge_hit  = ends_ok && ((ep_a == v_reg) || (ep_b == v_reg));
    assign w_comb    = (ep_a == v_reg) ? ep_b : ep_a;
    assign walk_hit  = ends_ok && (((ep_a == node_reg) && (ep_b == p_reg)) ||
                                   ((ep_b == node_reg) && (ep_a == p_reg)));
    assign last_edge = (e_reg + VTX_BITS'(1)) == cnt_reg;

    // status to the controller
    always_comb
    begin
        sts.item_op     = op_reg;
        sts.q_bad       = ({1'b0, a_reg} >= n) || ({1'b0, b_reg} >= n);
        sts.q_same      = a_reg == b_reg;
        sts.clr_last    = (clr_reg + CNT_BITS'(1)) == n;
        sts.stack_empty = sp_reg == '0;
        sts.visited     = vis_q;
        sts.is_tgt      = v_reg == b_reg;
        sts.no_edges    = cnt_reg == '0;
        sts.edge_hit    = edge_hit;
        sts.last_edge   = last_edge;
        sts.at_src      = node_reg == a_reg;
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    // operation decode
    always_comb
    begin
        vc_next         = vc_reg;
        cnt_next        = cnt_reg;
        sp_next         = sp_reg;
        e_next          = e_reg;
        clr_next        = clr_reg;
        v_next          = v_reg;
        w_next          = w_reg;
        node_next       = node_reg;
        p_next          = p_reg;
        best_next       = best_reg;
        res_cost_next   = res_cost_reg;
        res_status_next = res_status_reg;
        out_cost_next   = out_cost_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ep_we   = 1'b0;  ep_wa   = cnt_reg; ep_wd = {a_reg, b_reg};
        cost_we = 1'b0;  cost_wa = cnt_reg; cost_wd = cost_reg;
        vis_we  = 1'b0;  vis_wa  = v_reg;   vis_wd = 1'b1;
        par_we  = 1'b0;  par_wa  = w_reg;   par_wd = v_reg;
        stk_we  = 1'b0;  stk_wa  = sp_reg[VTX_BITS:0]; stk_wd = w_reg;
        ep_re   = 1'b0;
        vis_re  = 1'b0;  vis_ra  = stk_q;
        par_re  = 1'b0;
        stk_re  = 1'b0;  stk_ra  = (VTX_BITS+1)'(sp_reg - SP_BITS'(1));

        if (cfg_valid)
            vc_next = cfg_data;

        unique case (cmd.op)
            DP_EXEC:
            begin
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if (({1'b0, a_reg} < n) && ({1'b0, b_reg} < n) &&
                            (cnt_reg < EDGE_LIMIT))
                        begin
                            ep_we    = 1'b1;
                            cost_we  = 1'b1;
                            cnt_next = cnt_reg + VTX_BITS'(1);
                        end
                    end
                    OP_CHG:
                    begin
                        cost_wa = idx_reg;
                        cost_we = idx_reg < cnt_reg;
                    end
                    OP_CLR:
                        cnt_next = '0;
                    default:
                    begin
                    end
                endcase
            end
            DP_RES_BAD:
            begin
                res_cost_next   = COST_MIN;
                res_status_next = ST_UNREACH;
            end
            DP_RES_SAME:
            begin
                res_cost_next   = COST_MIN;
                res_status_next = ST_SAME;
            end
            DP_CLR_START:
                clr_next = '0;
            DP_CLR_STEP:
            begin
                vis_we   = 1'b1;
                vis_wa   = clr_reg[VTX_BITS-1:0];
                vis_wd   = 1'b0;
                clr_next = clr_reg + CNT_BITS'(1);
            end
            DP_PUSH_SRC:
            begin
                stk_we  = 1'b1;
                stk_wa  = '0;
                stk_wd  = a_reg;
                sp_next = SP_BITS'(1);
            end
            DP_POP:
            begin
                stk_re  = 1'b1;
                sp_next = sp_reg - SP_BITS'(1);
            end
            DP_VIS_RD_V:
            begin
                v_next = stk_q;
                vis_re = 1'b1;
                vis_ra = stk_q;
            end
            DP_MARK:
            begin
                vis_we    = 1'b1;
                e_next    = '0;
                node_next = b_reg;
                best_next = COST_MIN;
            end
            DP_EP_RD:
                ep_re = 1'b1;
            DP_VIS_RD_W:
            begin
                w_next = w_comb;
                vis_re = 1'b1;
                vis_ra = w_comb;
            end
            DP_LINK:
            begin
                if (!vis_q)
                begin
                    par_we = 1'b1;
                    if (!sp_reg[SP_BITS-1])
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + SP_BITS'(1);
                    end
                end
                e_next = e_reg + VTX_BITS'(1);
            end
            DP_NEXT_E:
                e_next = e_reg + VTX_BITS'(1);
            DP_RES_OK:
            begin
                res_cost_next   = best_reg;
                res_status_next = ST_OK;
            end
            DP_PAR_RD:
                par_re = 1'b1;
            DP_PAR_LATCH:
            begin
                p_next = par_q;
                e_next = '0;
            end
            DP_WALK_CMP:
            begin
                if (walk_hit && ($signed(cost_q) > $signed(best_reg)))
                    best_next = cost_q;
                e_next = e_reg + VTX_BITS'(1);
                if (last_edge)
                    node_next = p_reg;
            end
            DP_OUT:
            begin
                out_cost_next   = res_cost_reg;
                out_status_next = res_status_reg;
                out_valid_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg        <= VTX_LIMIT;
            cnt_reg       <= '0;
            sp_reg        <= '0;
            e_reg         <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vc_reg        <= vc_next;
            cnt_reg       <= cnt_next;
            sp_reg        <= sp_next;
            e_reg         <= e_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LATCH)
        begin
            op_reg   <= opcode;
            a_reg    <= node_a;
            b_reg    <= node_b;
            idx_reg  <= edge_sel;
            cost_reg <= edge_cost;
        end
        v_reg          <= v_next;
        w_reg          <= w_next;
        node_reg       <= node_next;
        p_reg          <= p_next;
        best_reg       <= best_next;
        res_cost_reg   <= res_cost_next;
        res_status_reg <= res_status_next;
        out_cost_reg   <= out_cost_next;
        out_status_reg <= out_status_next;
    end

    // edge store
    always_ff @(posedge clk)
    begin
        if (ep_we)
            ep_mem[ep_wa] <= ep_wd;
        if (cost_we)
            cost_mem[cost_wa] <= cost_wd;
        if (ep_re)
        begin
            ep_q   <= ep_mem[e_reg];
            cost_q <= cost_mem[e_reg];
        end
    end

    // visit marks
    always_ff @(posedge clk)
    begin
        if (vis_we)
            vis_mem[vis_wa] <= vis_wd;
        if (vis_re)
            vis_q <= vis_mem[vis_ra];
    end

    // parent table
    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[par_wa] <= par_wd;
        if (par_re)
            par_q <= par_mem[node_reg];
    end

    // search stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_wa] <= stk_wd;
        if (stk_re)
            stk_q <= stk_mem[stk_ra];
    end

    assign out_valid     = out_valid_reg;
    assign path_max_cost = out_cost_reg;
    assign query_status  = out_status_reg;

endmodule

@@ rtl/core/tpmq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpmq_ctrl
// Sequencer for the core: item decode, visit-mark clearing, depth-first
// search with edge scans, parent-chain walk and result hand-off.
// ----------------------------------------------------------------------------
module tpmq_ctrl
    import tpmq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_DECODE   = 15'b000000000000010,
        S_CLEAR    = 15'b000000000000100,
        S_PUSH     = 15'b000000000001000,
        S_POP      = 15'b000000000010000,
        S_POP_WAIT = 15'b000000000100000,
        S_VCHK     = 15'b000000001000000,
        S_SCAN_RD  = 15'b000000010000000,
        S_SCAN_EP  = 15'b000000100000000,
        S_SCAN_VIS = 15'b000001000000000,
        S_WALK_CHK = 15'b000010000000000,
        S_WALK_PAR = 15'b000100000000000,
        S_WALK_RD  = 15'b001000000000000,
        S_WALK_EP  = 15'b010000000000000,
        S_RESULT   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.item_op != OP_QUERY)
                begin
                    cmd.op     = DP_EXEC;
                    state_next = S_IDLE;
                end
                else if (sts.q_bad)
                begin
                    cmd.op     = DP_RES_BAD;
                    state_next = S_RESULT;
                end
                else if (sts.q_same)
                begin
                    cmd.op     = DP_RES_SAME;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.op     = DP_CLR_START;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.op = DP_CLR_STEP;
                if (sts.clr_last)
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.op     = DP_PUSH_SRC;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (sts.stack_empty)
                begin
                    cmd.op     = DP_RES_BAD;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.op     = DP_POP;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                cmd.op     = DP_VIS_RD_V;
                state_next = S_VCHK;
            end
            S_VCHK:
            begin
                if (sts.visited)
                    state_next = S_POP;
                else
                begin
                    cmd.op = DP_MARK;
                    if (sts.is_tgt)
                        state_next = S_WALK_CHK;
                    else if (sts.no_edges)
                        state_next = S_POP;
                    else
                        state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.op     = DP_EP_RD;
                state_next = S_SCAN_EP;
            end
            S_SCAN_EP:
            begin
                if (sts.edge_hit)
                begin
                    cmd.op     = DP_VIS_RD_W;
                    state_next = S_SCAN_VIS;
                end
                else
                begin
                    cmd.op     = DP_NEXT_E;
                    state_next = sts.last_edge ? S_POP : S_SCAN_RD;
                end
            end
            S_SCAN_VIS:
            begin
                cmd.op     = DP_LINK;
                state_next = sts.last_edge ? S_POP : S_SCAN_RD;
            end
            S_WALK_CHK:
            begin
                if (sts.at_src)
                begin
                    cmd.op     = DP_RES_OK;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.op     = DP_PAR_RD;
                    state_next = S_WALK_PAR;
                end
            end
            S_WALK_PAR:
            begin
                cmd.op     = DP_PAR_LATCH;
                state_next = S_WALK_RD;
            end
            S_WALK_RD:
            begin
                cmd.op     = DP_EP_RD;
                state_next = S_WALK_EP;
            end
            S_WALK_EP:
            begin
                cmd.op     = DP_WALK_CMP;
                state_next = sts.last_edge ? S_WALK_CHK : S_WALK_RD;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = DP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

@@ rtl/core/tree_path_max_edge_query_core.sv @@
// ----------------------------------------------------------------------------
// tree_path_max_edge_query_core
// Edge-weighted tree store with add, change, clear and path-maximum query.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid/in_stall carries one beat per command (opcode,
//   node_a, node_b, edge_sel, edge_cost); a beat is taken when in_valid is
//   high and in_stall low. Only a query returns a beat on the output channel
//   (path_max_cost, query_status), taken when out_valid is high and out_stall
//   low. vertex_count is to be written through cfg_valid/cfg_ready/cfg_data
//   only while the core is idle, which the core does not enforce; cfg_ready
//   is always high. Add, change and clear are latched, then run in the
//   decode state; a query with a bad or equal pair gets its result in decode
//   and hands it off from the result state. A full query clears the visit
//   marks, runs a depth-first search that scans every stored edge for each
//   vertex expanded, then walks the parent chain, scanning every edge at each
//   step, and ends with a check at the source. Reset sets vertex_count to
//   1024 and empties the edge store; no memory sweep is needed. A stalled
//   result sits in the output register; the core takes further commands
//   meanwhile and holds a new result until it drains.
// ----------------------------------------------------------------------------
module tree_path_max_edge_query_core
    import tpmq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNT_BITS-1:0]   cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            opcode,
    input  logic [VTX_BITS-1:0]   node_a,
    input  logic [VTX_BITS-1:0]   node_b,
    input  logic [VTX_BITS-1:0]   edge_sel,
    input  logic [COST_BITS-1:0]  edge_cost,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COST_BITS-1:0]  path_max_cost,
    output logic [1:0]            query_status
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencer
    tpmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stores and query datapath
    tpmq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .node_a        (node_a),
        .node_b        (node_b),
        .edge_sel      (edge_sel),
        .edge_cost     (edge_cost),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .path_max_cost (path_max_cost),
        .query_status  (query_status)
    );

`ifndef NO_ASSERTIONS
    // no status code beyond unreachable
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (query_status == ST_OK || query_status == ST_SAME ||
                       query_status == ST_UNREACH))
        else $error("illegal query status");

    // failed queries report the most negative cost
    a_fail_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && query_status != ST_OK) |-> path_max_cost == COST_MIN)
        else $error("failed query with non-minimum cost");

    // non-query commands never raise a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && opcode != OP_QUERY && !out_valid) |=> !out_valid)
        else $error("result raised by non-query command");
`endif

endmodule

@@ dv/tree_path_max_edge_query_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_path_max_edge_query_core_tb
// Self-checking bench for the path-maximum tree core. Plain tasks drive
// edge adds, cost changes, clears and queries, plus vertex_count writes
// between phases. A scoreboard keeps its own copy of the edge store, reruns
// the depth-first search and the parent walk for each accepted query whose
// pair is in range and distinct, and checks each result beat in order. Both
// channels idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tree_path_max_edge_query_core_tb;
    import tpmq_pkg::*;

    localparam int IDLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 90;

    typedef struct {
        logic [1:0]           op;
        logic [VTX_BITS-1:0]  a;
        logic [VTX_BITS-1:0]  b;
        logic [VTX_BITS-1:0]  idx;
        logic [COST_BITS-1:0] cost;
    } tb_cmd_t;

    typedef struct {
        logic [COST_BITS-1:0] cost;
        logic [1:0]           status;
    } answer_t;

    // ------------------------------------------------------------------------
    // path maximum scoreboard
    // ------------------------------------------------------------------------
    class path_max_scoreboard_t;
        logic [CNT_BITS-1:0]  vcount;
        logic [VTX_BITS-1:0]  end_a [MAX_EDGES];
        logic [VTX_BITS-1:0]  end_b [MAX_EDGES];
        logic [COST_BITS-1:0] ecost [MAX_EDGES];
        int                   n_edges;
        int                   parent [MAX_VERTICES];
        bit                   seen [MAX_VERTICES];
        answer_t              pending [$];
        int                   mismatches;

        function new();
            vcount = 11'd1024;
            n_edges = 0;
            mismatches = 0;
        endfunction

        function int live_n();
            if (vcount == 0) return 1;
            if (vcount > MAX_VERTICES) return MAX_VERTICES;
            return vcount;
        endfunction

        // other end of edge e seen from v, -1 if not usable
        function int far_end(int e, int v, int n);
            if (end_a[e] >= n || end_b[e] >= n) return -1;
            if (end_a[e] == v) return end_b[e];
            if (end_b[e] == v) return end_a[e];
            return -1;
        endfunction

        function void dfs(int src, int tgt, int n);
            int stk [$];
            int v;
            int w;
            for (int i = 0; i < n; i++)
            begin
                parent[i] = i;
                seen[i] = 0;
            end
            stk = {stk, src};
            while (stk.size() > 0)
            begin
                v = stk.pop_back();
                if (seen[v]) continue;
                seen[v] = 1;
                if (v == tgt) break;
                for (int e = 0; e < n_edges; e++)
                begin
                    w = far_end(e, v, n);
                    if (w >= 0 && !seen[w])
                    begin
                        parent[w] = v;
                        if (stk.size() < STACK_DEPTH) stk = {stk, w};
                    end
                end
            end
        endfunction

        function logic [COST_BITS-1:0] walk_max(int src, int tgt, int n);
            logic signed [COST_BITS-1:0] top;
            int node;
            int p;
            int steps;
            top = COST_MIN;
            node = tgt;
            steps = 0;
            while (node != src && steps < n)
            begin
                p = parent[node];
                for (int e = 0; e < n_edges; e++)
                    if (far_end(e, node, n) == p && $signed(ecost[e]) > top)
                        top = ecost[e];
                node = p;
                steps++;
            end
            return top;
        endfunction

        function void note_input(tb_cmd_t c);
            int n;
            answer_t r;
            n = live_n();
            case (c.op)
                OP_ADD:
                    if (c.a < n && c.b < n && n_edges < MAX_EDGES)
                    begin
                        end_a[n_edges] = c.a;
                        end_b[n_edges] = c.b;
                        ecost[n_edges] = c.cost;
                        n_edges++;
                    end
                OP_CHG:
                    if (c.idx < n_edges) ecost[c.idx] = c.cost;
                OP_CLR:
                    n_edges = 0;
                default:
                begin
                    r.cost = COST_MIN;
                    if (c.a >= n || c.b >= n)
                        r.status = ST_UNREACH;
                    else if (c.a == c.b)
                        r.status = ST_SAME;
                    else
                    begin
                        dfs(c.a, c.b, n);
                        if (!seen[c.b])
                            r.status = ST_UNREACH;
                        else
                        begin
                            r.status = ST_OK;
                            r.cost = walk_max(c.a, c.b, n);
                        end
                    end
                    pending = {pending, r};
                end
            endcase
        endfunction

        function void check_result(logic [COST_BITS-1:0] cost, logic [1:0] status);
            answer_t r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat cost=%0d status=%0d",
                             $signed(cost), status);
                return;
            end
            r = pending.pop_front();
            if (r.cost !== cost || r.status !== status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result mismatch: exp cost=%0d status=%0d, got cost=%0d status=%0d",
                             $signed(r.cost), r.status, $signed(cost), status);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CNT_BITS-1:0]  cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           opcode;
    logic [VTX_BITS-1:0]  node_a;
    logic [VTX_BITS-1:0]  node_b;
    logic [VTX_BITS-1:0]  edge_sel;
    logic [COST_BITS-1:0] edge_cost;
    logic                 out_valid;
    logic                 out_stall;
    logic [COST_BITS-1:0] path_max_cost;
    logic [1:0]           query_status;

    path_max_scoreboard_t sb;
    int  idle_cycles;
    bit  calm_send;
    bit  calm_recv;
    bit  hold_go;
    bit  hold_done;
    int  random_sent;

    tree_path_max_edge_query_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .node_a        (node_a),
        .node_b        (node_b),
        .edge_sel      (edge_sel),
        .edge_cost     (edge_cost),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .path_max_cost (path_max_cost),
        .query_status  (query_status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // beat monitor, checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            tb_cmd_t c;
            bit moved;
            moved = 0;
            if (in_valid && !in_stall)
            begin
                c.op = opcode;
                c.a = node_a;
                c.b = node_b;
                c.idx = edge_sel;
                c.cost = edge_cost;
                sb.note_input(c);
                moved = 1;
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(path_max_cost, query_status);
                moved = 1;
            end
            if (cfg_valid && cfg_ready) moved = 1;
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int g;
        out_stall = 1'b0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_done = 1;
            end
            g = calm_recv ? 0 : pick_gap();
            if (g > 0)
            begin
                out_stall <= 1'b1;
                repeat (g - 1) @(posedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // one command beat
    task automatic send_cmd(input tb_cmd_t c);
        int g;
        g = calm_send ? 0 : pick_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        opcode <= c.op;
        node_a <= c.a;
        node_b <= c.b;
        edge_sel <= c.idx;
        edge_cost <= c.cost;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send(input logic [1:0] op, input int a, input int b,
                        input int idx, input logic [COST_BITS-1:0] cost);
        tb_cmd_t c;
        c.op = op;
        c.a = VTX_BITS'(a);
        c.b = VTX_BITS'(b);
        c.idx = VTX_BITS'(idx);
        c.cost = cost;
        send_cmd(c);
    endtask

    // stop sending and wait for every result to drain
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_vcount(input logic [CNT_BITS-1:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.vcount = v;
    endtask

    // random well-formed tree session with some noise mixed in
    task automatic tree_session(input int vc, input bit with_hold);
        int n;
        int na;
        int base [$];
        int u;
        int v;
        n = (vc == 0) ? 1 : ((vc > MAX_VERTICES) ? MAX_VERTICES : vc);
        write_vcount(CNT_BITS'(vc));
        calm_send = ($urandom_range(0, 3) == 0);
        calm_recv = ($urandom_range(0, 3) == 0);
        send(OP_CLR, $urandom, $urandom, $urandom, $urandom);
        // build a tree over a subset of the vertices
        na = (n > 40) ? $urandom_range(2, 12) : n;
        base.delete();
        for (int i = 0; i < na; i++)
        begin
            v = (n > 40) ? $urandom_range(0, n - 1) : i;
            if (i > 0)
            begin
                u = base[$urandom_range(0, base.size() - 1)];
                if ($urandom_range(0, 1)) send(OP_ADD, u, v, 0, $urandom);
                else send(OP_ADD, v, u, 0, $urandom);
                random_sent++;
            end
            base = {base, v};
        end
        if (with_hold) hold_go = 1;
        for (int k = 0; k < 12; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    send(OP_CHG, 0, 0, $urandom_range(0, na), $urandom);
                2:
                    send(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                         $urandom);
                3:
                    send(OP_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                         0, $urandom);
                default:
                    send(OP_QUERY, base[$urandom_range(0, na - 1)],
                         base[$urandom_range(0, na - 1)], 0, 0);
            endcase
            random_sent++;
        end
    endtask

    initial
    begin
        int vcs [8];
        sb = new();
        idle_cycles = 0;
        random_sent = 0;
        calm_send = 0;
        calm_recv = 0;
        hold_go = 0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_CLR;
        node_a = '0;
        node_b = '0;
        edge_sel = '0;
        edge_cost = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: equal pair, empty store, extreme costs, parallel edges, cycle
        send(OP_QUERY, 0, 0, 0, 0);
        send(OP_QUERY, 0, 1, 0, 0);
        send(OP_ADD, 0, 1, 0, 32'h7fff_ffff);
        send(OP_ADD, 1, 2, 0, 32'h8000_0000);
        send(OP_ADD, 1023, 1022, 0, -5);
        send(OP_ADD, 2, 1023, 0, 0);
        send(OP_QUERY, 0, 2, 0, 0);
        send(OP_QUERY, 1022, 0, 0, 0);
        send(OP_CHG, 0, 0, 0, 5);
        send(OP_CHG, 0, 0, 1022, 9);
        send(OP_QUERY, 1023, 0, 0, 0);
        send(OP_ADD, 5, 5, 0, 1);
        send(OP_QUERY, 3, 4, 0, 0);
        send(OP_ADD, 1, 0, 0, 100);
        send(OP_QUERY, 1, 0, 0, 0);
        send(OP_ADD, 0, 2, 0, 3);
        send(OP_QUERY, 0, 1023, 0, 0);
        // shrink: out-of-range endpoints become absent or ignored
        write_vcount(11'd4);
        send(OP_QUERY, 1023, 0, 0, 0);
        send(OP_ADD, 3, 1000, 0, 77);
        send(OP_QUERY, 2, 0, 0, 0);
        send(OP_QUERY, 3, 0, 0, 0);
        send(OP_CLR, 0, 0, 0, 0);
        send(OP_QUERY, 2, 0, 0, 0);

        // chain across the vertex range at full count
        write_vcount(11'd1024);
        calm_send = 1;
        for (int i = 0; i < 16; i++) send(OP_ADD, i * 60, (i + 1) * 60, 0, i);
        calm_send = 0;
        send(OP_QUERY, 0, 60, 0, 0);
        send(OP_QUERY, 960, 900, 0, 0);
        send(OP_CHG, 0, 0, 15, -1);
        send(OP_QUERY, 960, 0, 0, 0);
        send(OP_QUERY, 0, 960, 0, 0);
        send(OP_QUERY, 0, 1023, 0, 0);
        send(OP_CLR, 0, 0, 0, 0);

        // register values outside the usable range
        write_vcount(11'd0);
        send(OP_QUERY, 0, 0, 0, 0);
        send(OP_ADD, 0, 0, 0, 4);
        send(OP_QUERY, 0, 1, 0, 0);
        write_vcount(11'd2047);
        send(OP_CLR, 0, 0, 0, 0);
        send(OP_QUERY, 5, 6, 0, 0);

        // random sessions
        vcs = '{1, 2, 3, 8, 16, 31, 64, 1024};
        tree_session(16, 1);
        while (random_sent < RANDOM_ITEMS)
            tree_session(vcs[$urandom_range(0, 7)], 0);

        drain();
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tpmq_pkg.sv
rtl/core/tpmq_datapath.sv
rtl/core/tpmq_ctrl.sv
rtl/core/tree_path_max_edge_query_core.sv
dv/tree_path_max_edge_query_core_tb.sv
